[rtl/pkp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkp_pkg
// Types, codes, field positions and saturation helpers for the kernel
// perceptron block.
// ----------------------------------------------------------------------------
package pkp_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_SCORE   = 2'd2,
        CMD_AVERAGE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BEYOND = 2'd1,
        ST_FULL   = 2'd2,
        ST_UNUSED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_BIAS  = 2'd0,
        CFG_POWER = 2'd1,
        CFG_SCALE = 2'd2,
        CFG_NONE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_UPD_RD,
        S_UPD_MUL,
        S_UPD_WR,
        S_EL_RUN,
        S_SC_RD,
        S_SC_K,
        S_PW_MUL,
        S_PW_NORM,
        S_TM_MUL,
        S_TM_ACC,
        S_AV_RD,
        S_AV_LD,
        S_AV_DIV,
        S_AV_WR
    } state_t;

    // input beat tdata layout, lowest bit first
    localparam int IN_TDATA_W = 56;
    localparam int IN_VIDX_LO = 0;
    localparam int IN_DIDX_LO = 9;
    localparam int IN_ELEM_LO = 15;
    localparam int IN_CHG_LO  = 31;
    localparam int IN_AVG_BIT = 55;

    // result beat tdata layout
    localparam int OUT_TDATA_W = 64;

    localparam logic signed [31:0] P_ONE = 32'sh0001_0000;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_0000_7FFF) return 16'sh7FFF;
        if (v < 64'shFFFF_FFFF_FFFF_8000) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_007F_FFFF) return 24'sh7F_FFFF;
        if (v < 64'shFFFF_FFFF_FF80_0000) return 24'sh80_0000;
        return v[23:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < 64'shFFFF_FFFF_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < 64'shFFFF_8000_0000_0000) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

endpackage

[rtl/polynomial_kernel_perceptron.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_kernel_perceptron
// Averaged polynomial kernel perceptron store with a shared multiplier.
// ----------------------------------------------------------------------------
// One beat at a time; s_axis_tready is high only while the sequencer idles.
// A vector element write is done as the beat is accepted. A weight update reads
// the vector's weights, multiplies the change by the scale and writes both back
// (a refused one ends after the read). A score element with an in-range dim
// index walks every slot of the partial dot memory through the issue, multiply
// and accumulate stages. The last score element then takes each stored vector
// through the shared multiplier, kernel_power times for the power and once for
// the weight, steps over each empty slot and hands off the result. An average
// recompute runs each stored vector through the divider, one quotient bit per
// cycle. A result that cannot enter the stalled output register holds the input
// off until it does. After reset a clearing pass over every slot zeroes the
// partial dots before the first beat is taken.
module polynomial_kernel_perceptron #(
    parameter int MAX_VECTORS = 256,
    parameter int VECTOR_DIM  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vector_index[8:0], dim_index[14:9], element_value[30:15],
    // weight_change[54:31], use_average[55]
    input  logic [55:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    // last_element
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // score[47:0], status[49:48], vector_count[58:50]
    output logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int VW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int CW = $clog2(MAX_VECTORS + 1);
    localparam int SD = MAX_VECTORS * VECTOR_DIM;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;

    // memories
    logic signed [15:0] store_mem [SD];
    logic signed [23:0] alpha_mem [MAX_VECTORS];
    logic signed [47:0] beta_mem  [MAX_VECTORS];
    logic signed [23:0] avg_mem   [MAX_VECTORS];
    logic signed [47:0] pd_mem    [MAX_VECTORS];

    logic signed [15:0] st_q;
    logic signed [23:0] alpha_q;
    logic signed [47:0] beta_q;
    logic signed [23:0] avg_q;
    logic signed [47:0] pd_q;

    logic               st_we;
    logic [AW-1:0]      st_addr;
    logic signed [15:0] st_wd;
    logic               ab_we;
    logic               avg_we;
    logic [VW-1:0]      ab_addr;
    logic signed [23:0] alpha_wd;
    logic signed [47:0] beta_wd;
    logic signed [23:0] avg_wd;
    logic               pd_we;
    logic [VW-1:0]      pd_wa;
    logic [VW-1:0]      pd_ra;
    logic signed [47:0] pd_wd;

    // control
    pkp_pkg::state_t    state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [15:0] bias_reg, bias_next;
    logic [3:0]         power_reg, power_next;
    logic [15:0]        scale_reg, scale_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;

    // payload
    logic [8:0]         vidx_reg, vidx_next;
    logic signed [15:0] elem_reg, elem_next;
    logic signed [23:0] chg_reg, chg_next;
    logic               avg_sel_reg, avg_sel_next;
    logic               last_reg, last_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [VW-1:0]      idx1_reg, idx1_next;
    logic [VW-1:0]      idx2_reg, idx2_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [47:0] pd_hold_reg, pd_hold_next;
    logic signed [15:0] k_reg, k_next;
    logic signed [23:0] w_reg, w_next;
    logic signed [31:0] p_reg, p_next;
    logic [3:0]         pw_cnt_reg, pw_cnt_next;
    logic signed [47:0] total_reg, total_next;
    logic               neg_reg, neg_next;
    logic [47:0]        mag_reg, mag_next;
    logic [15:0]        rem_reg, rem_next;
    logic [5:0]         bit_reg, bit_next;
    logic signed [23:0] alpha_hold_reg, alpha_hold_next;
    logic signed [47:0] res_score_reg, res_score_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [63:0]        out_data_reg, out_data_next;
    logic               emit_reg, emit_next;

    // shared multiplier
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [15:0]        c_val;
    logic signed [63:0] y_val;
    logic [16:0]        rem_sh;
    logic signed [63:0] q_val;
    logic               vidx_lt, vidx_gt;

    assign c_val   = (scale_reg == 16'd0) ? 16'd1 : scale_reg;
    assign vidx_lt = 16'(vidx_reg) < 16'(count_reg);
    assign vidx_gt = 16'(vidx_reg) > 16'(count_reg);
    assign y_val   = 64'(pd_q) + (64'(bias_reg) <<< 12);
    assign rem_sh  = {rem_reg, mag_reg[47]};
    assign q_val   = neg_reg ? -$signed({16'd0, mag_reg}) : $signed({16'd0, mag_reg});

    assign s_axis_tready = (state_reg == pkp_pkg::S_IDLE) && !emit_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        count_next      = count_reg;
        bias_next       = bias_reg;
        power_next      = power_reg;
        scale_next      = scale_reg;
        idx_next        = idx_reg;
        v1_next         = 1'b0;
        v2_next         = 1'b0;
        vidx_next       = vidx_reg;
        elem_next       = elem_reg;
        chg_next        = chg_reg;
        avg_sel_next    = avg_sel_reg;
        last_next       = last_reg;
        base_next       = base_reg;
        idx1_next       = idx1_reg;
        idx2_next       = idx2_reg;
        prod_next       = prod_reg;
        pd_hold_next    = pd_hold_reg;
        k_next          = k_reg;
        w_next          = w_reg;
        p_next          = p_reg;
        pw_cnt_next     = pw_cnt_reg;
        total_next      = total_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        alpha_hold_next = alpha_hold_reg;
        res_score_next  = res_score_reg;
        res_status_next = res_status_reg;
        out_data_next   = out_data_reg;
        emit_next       = emit_reg;
        st_we    = 1'b0;
        st_addr  = base_reg;
        st_wd    = elem_reg;
        ab_we    = 1'b0;
        avg_we   = 1'b0;
        ab_addr  = idx_reg[VW-1:0];
        alpha_wd = chg_reg;
        beta_wd  = prod_reg[47:0];
        avg_wd   = 24'sd0;
        pd_we    = 1'b0;
        pd_wa    = idx_reg[VW-1:0];
        pd_ra    = idx_reg[VW-1:0];
        pd_wd    = 48'sd0;
        mul_a    = 32'sd0;
        mul_b    = 32'sd0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (pkp_pkg::cfg_idx_t'(cfg_index))
                pkp_pkg::CFG_BIAS:  bias_next  = cfg_data;
                pkp_pkg::CFG_POWER: power_next = cfg_data[3:0];
                pkp_pkg::CFG_SCALE: scale_next = cfg_data;
                default: ;
            endcase
        end

        // hand a finished result to the output register
        if (emit_reg && (!out_valid_reg || m_axis_tready))
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0, 9'(count_reg), res_status_reg, res_score_reg};
            emit_next      = 1'b0;
        end

        unique case (state_reg)
            pkp_pkg::S_CLR:
            begin
                pd_we = 1'b1;
                if (idx_reg == CW'(MAX_VECTORS - 1))
                begin
                    idx_next   = '0;
                    state_next = pkp_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pkp_pkg::S_IDLE:
            begin
                if (s_axis_tvalid && !emit_reg)
                begin
                    vidx_next    = s_axis_tdata[pkp_pkg::IN_VIDX_LO +: 9];
                    elem_next    = s_axis_tdata[pkp_pkg::IN_ELEM_LO +: 16];
                    chg_next     = s_axis_tdata[pkp_pkg::IN_CHG_LO +: 24];
                    avg_sel_next = s_axis_tdata[pkp_pkg::IN_AVG_BIT];
                    last_next    = s_axis_tlast;
                    idx_next     = '0;
                    total_next   = 48'sd0;
                    base_next    = AW'(s_axis_tdata[pkp_pkg::IN_DIDX_LO +: 6]);
                    unique case (pkp_pkg::cmd_t'(s_axis_tuser))
                        pkp_pkg::CMD_WRITE:
                        begin
                            if (32'(s_axis_tdata[pkp_pkg::IN_VIDX_LO +: 9]) < MAX_VECTORS &&
                                32'(s_axis_tdata[pkp_pkg::IN_DIDX_LO +: 6]) < VECTOR_DIM)
                            begin
                                st_we   = 1'b1;
                                st_addr = AW'(32'(s_axis_tdata[pkp_pkg::IN_VIDX_LO +: 9])
                                          * VECTOR_DIM
                                          + 32'(s_axis_tdata[pkp_pkg::IN_DIDX_LO +: 6]));
                                st_wd   = s_axis_tdata[pkp_pkg::IN_ELEM_LO +: 16];
                            end
                        end
                        pkp_pkg::CMD_UPDATE:
                        begin
                            state_next = pkp_pkg::S_UPD_RD;
                        end
                        pkp_pkg::CMD_SCORE:
                        begin
                            if (32'(s_axis_tdata[pkp_pkg::IN_DIDX_LO +: 6]) < VECTOR_DIM)
                            begin
                                state_next = pkp_pkg::S_EL_RUN;
                            end
                            else if (s_axis_tlast)
                            begin
                                state_next = pkp_pkg::S_SC_RD;
                            end
                        end
                        pkp_pkg::CMD_AVERAGE:
                        begin
                            state_next = pkp_pkg::S_AV_RD;
                        end
                    endcase
                end
            end
            pkp_pkg::S_UPD_RD:
            begin
                ab_addr        = vidx_reg[VW-1:0];
                res_score_next = 48'sd0;
                if (vidx_gt)
                begin
                    res_status_next = pkp_pkg::ST_BEYOND;
                    emit_next       = 1'b1;
                    state_next      = pkp_pkg::S_IDLE;
                end
                else if (!vidx_lt && 32'(count_reg) >= MAX_VECTORS)
                begin
                    res_status_next = pkp_pkg::ST_FULL;
                    emit_next       = 1'b1;
                    state_next      = pkp_pkg::S_IDLE;
                end
                else
                begin
                    state_next = pkp_pkg::S_UPD_MUL;
                end
            end
            pkp_pkg::S_UPD_MUL:
            begin
                ab_addr    = vidx_reg[VW-1:0];
                mul_a      = 32'(chg_reg);
                mul_b      = $signed({16'd0, c_val});
                prod_next  = mul_p;
                state_next = pkp_pkg::S_UPD_WR;
            end
            pkp_pkg::S_UPD_WR:
            begin
                ab_we   = 1'b1;
                ab_addr = vidx_reg[VW-1:0];
                if (vidx_lt)
                begin
                    alpha_wd = pkp_pkg::sat24(64'(alpha_q) + 64'(chg_reg));
                    beta_wd  = pkp_pkg::sat48(64'(beta_q) + prod_reg);
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
                res_status_next = pkp_pkg::ST_OK;
                emit_next       = 1'b1;
                state_next      = pkp_pkg::S_IDLE;
            end
            pkp_pkg::S_EL_RUN:
            begin
                // issue stage: one slot per cycle
                if (32'(idx_reg) < MAX_VECTORS)
                begin
                    st_addr   = base_reg;
                    pd_ra     = idx_reg[VW-1:0];
                    v1_next   = 1'b1;
                    idx1_next = idx_reg[VW-1:0];
                    idx_next  = idx_reg + 1'b1;
                    base_next = base_reg + AW'(VECTOR_DIM);
                end
                // multiply stage
                if (v1_reg)
                begin
                    mul_a        = 32'(st_q);
                    mul_b        = 32'(elem_reg);
                    prod_next    = mul_p;
                    pd_hold_next = pd_q;
                    idx2_next    = idx1_reg;
                end
                v2_next = v1_reg;
                // accumulate stage
                if (v2_reg)
                begin
                    pd_we = 1'b1;
                    pd_wa = idx2_reg;
                    pd_wd = pkp_pkg::sat48(64'(pd_hold_reg) + prod_reg);
                end
                if (32'(idx_reg) >= MAX_VECTORS && !v1_reg && !v2_reg)
                begin
                    idx_next   = '0;
                    state_next = last_reg ? pkp_pkg::S_SC_RD : pkp_pkg::S_IDLE;
                end
            end
            pkp_pkg::S_SC_RD:
            begin
                if (32'(idx_reg) >= MAX_VECTORS)
                begin
                    res_score_next  = total_reg;
                    res_status_next = pkp_pkg::ST_OK;
                    emit_next       = 1'b1;
                    state_next      = pkp_pkg::S_IDLE;
                end
                else
                begin
                    // read the dot, then clear the slot for the next score
                    pd_we = 1'b1;
                    if (idx_reg < count_reg)
                    begin
                        state_next = pkp_pkg::S_SC_K;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            pkp_pkg::S_SC_K:
            begin
                k_next      = pkp_pkg::sat16((y_val + 64'sd32768) >>> 16);
                w_next      = avg_sel_reg ? avg_q : alpha_q;
                p_next      = pkp_pkg::P_ONE;
                pw_cnt_next = power_reg;
                state_next  = (power_reg == 4'd0) ? pkp_pkg::S_TM_MUL : pkp_pkg::S_PW_MUL;
            end
            pkp_pkg::S_PW_MUL:
            begin
                mul_a      = p_reg;
                mul_b      = 32'(k_reg);
                prod_next  = mul_p;
                state_next = pkp_pkg::S_PW_NORM;
            end
            pkp_pkg::S_PW_NORM:
            begin
                p_next      = pkp_pkg::sat32((prod_reg + 64'sd128) >>> 8);
                pw_cnt_next = pw_cnt_reg - 1'b1;
                state_next  = (pw_cnt_reg == 4'd1) ? pkp_pkg::S_TM_MUL : pkp_pkg::S_PW_MUL;
            end
            pkp_pkg::S_TM_MUL:
            begin
                mul_a      = 32'(w_reg);
                mul_b      = p_reg;
                prod_next  = mul_p;
                state_next = pkp_pkg::S_TM_ACC;
            end
            pkp_pkg::S_TM_ACC:
            begin
                total_next = pkp_pkg::sat48(64'(total_reg) + ((prod_reg + 64'sd128) >>> 8));
                idx_next   = idx_reg + 1'b1;
                state_next = pkp_pkg::S_SC_RD;
            end
            pkp_pkg::S_AV_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = pkp_pkg::S_IDLE;
                end
                else
                begin
                    state_next = pkp_pkg::S_AV_LD;
                end
            end
            pkp_pkg::S_AV_LD:
            begin
                neg_next        = beta_q[47];
                mag_next        = beta_q[47] ? 48'(-beta_q) : 48'(beta_q);
                alpha_hold_next = alpha_q;
                rem_next        = 16'd0;
                bit_next        = 6'd47;
                state_next      = pkp_pkg::S_AV_DIV;
            end
            pkp_pkg::S_AV_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, c_val})
                begin
                    rem_next = 16'(rem_sh - {1'b0, c_val});
                    mag_next = {mag_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[15:0];
                    mag_next = {mag_reg[46:0], 1'b0};
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == 6'd0)
                begin
                    state_next = pkp_pkg::S_AV_WR;
                end
            end
            pkp_pkg::S_AV_WR:
            begin
                avg_we     = 1'b1;
                avg_wd     = pkp_pkg::sat24(64'(alpha_hold_reg) - q_val);
                idx_next   = idx_reg + 1'b1;
                state_next = pkp_pkg::S_AV_RD;
            end
            default:
            begin
                state_next = pkp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pkp_pkg::S_CLR;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            bias_reg      <= 16'sd0;
            power_reg     <= 4'd1;
            scale_reg     <= 16'd1;
            idx_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            emit_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            bias_reg      <= bias_next;
            power_reg     <= power_next;
            scale_reg     <= scale_next;
            idx_reg       <= idx_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            emit_reg      <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vidx_reg       <= vidx_next;
        elem_reg       <= elem_next;
        chg_reg        <= chg_next;
        avg_sel_reg    <= avg_sel_next;
        last_reg       <= last_next;
        base_reg       <= base_next;
        idx1_reg       <= idx1_next;
        idx2_reg       <= idx2_next;
        prod_reg       <= prod_next;
        pd_hold_reg    <= pd_hold_next;
        k_reg          <= k_next;
        w_reg          <= w_next;
        p_reg          <= p_next;
        pw_cnt_reg     <= pw_cnt_next;
        total_reg      <= total_next;
        neg_reg        <= neg_next;
        mag_reg        <= mag_next;
        rem_reg        <= rem_next;
        bit_reg        <= bit_next;
        alpha_hold_reg <= alpha_hold_next;
        res_score_reg  <= res_score_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_addr] <= st_wd;
        end
        st_q <= store_mem[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ab_we)
        begin
            alpha_mem[ab_addr] <= alpha_wd;
            beta_mem[ab_addr]  <= beta_wd;
        end
        alpha_q <= alpha_mem[ab_addr];
        beta_q  <= beta_mem[ab_addr];
    end

    always_ff @(posedge clk)
    begin
        if (avg_we)
        begin
            avg_mem[ab_addr] <= avg_wd;
        end
        avg_q <= avg_mem[ab_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pd_we)
        begin
            pd_mem[pd_wa] <= pd_wd;
        end
        pd_q <= pd_mem[pd_ra];
    end

endmodule

[rtl/pkp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkp_port_checker
// Port-level checks for the kernel perceptron block.
// ----------------------------------------------------------------------------
module pkp_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // an update beat always starts a multi-cycle sequence
    a_upd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == pkp_pkg::CMD_UPDATE
        |=> !s_axis_tready)
        else $error("input accepted right after an update beat");

    // status never carries the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[49:48] != pkp_pkg::ST_UNUSED)
        else $error("invalid status code");

    // a beat other than an update that is not last never produces a result next cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast
        && s_axis_tuser != pkp_pkg::CMD_UPDATE && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result without a causing beat");

endmodule

bind polynomial_kernel_perceptron pkp_port_checker u_pkp_port_checker (.*);
